FILE: hw/rtl/ersseq_pkg.sv
// Types and constants for the extend/retract stall sequencer.
// No dependencies; used by extend_retract_stall_sequencer_core.
package ersseq_pkg;

   localparam int CodeWidth    = 11;
   localparam int ThreshWidth  = 16;
   localparam int CountWidth   = 8;
   localparam int DriveWidth   = 16;
   localparam int StateWidth   = 2;
   localparam int CsrIdxWidth  = 8;
   localparam int CsrDataWidth = 16;

   // Register indexes on the csr port
   localparam logic [CsrIdxWidth-1:0] RegChanHigh  = 8'd0;
   localparam logic [CsrIdxWidth-1:0] RegChanLow   = 8'd1;
   localparam logic [CsrIdxWidth-1:0] RegRunThresh = 8'd2;
   localparam logic [CsrIdxWidth-1:0] RegStopThresh= 8'd3;
   localparam logic [CsrIdxWidth-1:0] RegStopLimit = 8'd4;
   localparam logic [CsrIdxWidth-1:0] RegExtDrive  = 8'd5;
   localparam logic [CsrIdxWidth-1:0] RegRetDrive  = 8'd6;
   localparam logic [CsrIdxWidth-1:0] RegHoldDrive = 8'd7;

   // Register reset values
   localparam logic [CodeWidth-1:0]   ChanHighReset  = 11'd1792;
   localparam logic [CodeWidth-1:0]   ChanLowReset   = 11'd192;
   localparam logic [ThreshWidth-1:0] RunThreshReset = 16'd100;
   localparam logic [ThreshWidth-1:0] StopThreshReset= 16'd20;
   localparam logic [CountWidth-1:0]  StopLimitReset = 8'd10;
   localparam logic [DriveWidth-1:0]  ExtDriveReset  = 16'd3000;
   localparam logic [DriveWidth-1:0]  RetDriveReset  = 16'hF448; // -3000
   localparam logic [DriveWidth-1:0]  HoldDriveReset = 16'd500;

   // Motion state codes as reported on the result channel
   localparam logic [StateWidth-1:0] CodeRetracted  = 2'd0;
   localparam logic [StateWidth-1:0] CodeExtending  = 2'd1;
   localparam logic [StateWidth-1:0] CodeExtended   = 2'd2;
   localparam logic [StateWidth-1:0] CodeRetracting = 2'd3;

   typedef enum logic [3:0] {
      PH_RETRACTED  = 4'b0001,
      PH_EXTENDING  = 4'b0010,
      PH_EXTENDED   = 4'b0100,
      PH_RETRACTING = 4'b1000
   } phase_type;

   function automatic logic [StateWidth-1:0] phase_code(input phase_type ph);
      logic [StateWidth-1:0] code;
      case (ph)
         PH_RETRACTED:  code = CodeRetracted;
         PH_EXTENDING:  code = CodeExtending;
         PH_EXTENDED:   code = CodeExtended;
         PH_RETRACTING: code = CodeRetracting;
         default:       code = CodeRetracted;
      endcase
      return code;
   endfunction

endpackage

FILE: hw/rtl/extend_retract_stall_sequencer_core.sv
// Extend/retract stall sequencer: top level.
// Depends on ersseq_pkg for types, register indexes and reset values.
// The request transaction is captured in the input register and then passes to the result
// register, where rsp_valid rises; a full result register that is not taken holds it back.
// Throughput: one transaction per cycle unless rsp stalls; both registers advance together.
// Reset (synchronous, active high): registers return to their default values, the edge flags,
// seen-motion flag and stall counter clear, the phase returns to retracted, both stages empty.
module extend_retract_stall_sequencer_core #(
   parameter int SPEED_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [ersseq_pkg::CodeWidth-1:0]       req_channel_value,
   input  logic signed [SPEED_WIDTH-1:0]          req_motor1_rpm,
   input  logic signed [SPEED_WIDTH-1:0]          req_motor2_rpm,
   input  logic                                   req_lift_raising,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [ersseq_pkg::DriveWidth-1:0] rsp_drive_value,
   output logic [ersseq_pkg::StateWidth-1:0]      rsp_motion_state,
   output logic                                   rsp_end_reached,
   // configuration write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ersseq_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [ersseq_pkg::CsrDataWidth-1:0]    csr_wdata
);

   localparam int CW  = ersseq_pkg::CodeWidth;
   localparam int TW  = ersseq_pkg::ThreshWidth;
   localparam int NW  = ersseq_pkg::CountWidth;
   localparam int DW  = ersseq_pkg::DriveWidth;
   // compare width covers both the speed magnitude and the 16-bit thresholds
   localparam int CMP_W = (SPEED_WIDTH > TW) ? SPEED_WIDTH : TW;

   // ---------------- configuration registers ----------------
   logic [CW-1:0] chan_high_ff, chan_low_ff;
   logic [TW-1:0] run_thresh_ff, stop_thresh_ff;
   logic [NW-1:0] stop_limit_ff;
   logic [DW-1:0] ext_drive_ff, ret_drive_ff, hold_drive_ff;

   // Writes must arrive only while idle; the block itself does not enforce this, csr_ready stays high.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_high_ff   <= ersseq_pkg::ChanHighReset;
         chan_low_ff    <= ersseq_pkg::ChanLowReset;
         run_thresh_ff  <= ersseq_pkg::RunThreshReset;
         stop_thresh_ff <= ersseq_pkg::StopThreshReset;
         stop_limit_ff  <= ersseq_pkg::StopLimitReset;
         ext_drive_ff   <= ersseq_pkg::ExtDriveReset;
         ret_drive_ff   <= ersseq_pkg::RetDriveReset;
         hold_drive_ff  <= ersseq_pkg::HoldDriveReset;
      end else if (csr_valid && csr_ready) begin
         // drop writes to unknown indexes
         case (csr_index)
            ersseq_pkg::RegChanHigh:   chan_high_ff   <= csr_wdata[CW-1:0];
            ersseq_pkg::RegChanLow:    chan_low_ff    <= csr_wdata[CW-1:0];
            ersseq_pkg::RegRunThresh:  run_thresh_ff  <= csr_wdata[TW-1:0];
            ersseq_pkg::RegStopThresh: stop_thresh_ff <= csr_wdata[TW-1:0];
            ersseq_pkg::RegStopLimit:  stop_limit_ff  <= csr_wdata[NW-1:0];
            ersseq_pkg::RegExtDrive:   ext_drive_ff   <= csr_wdata[DW-1:0];
            ersseq_pkg::RegRetDrive:   ret_drive_ff   <= csr_wdata[DW-1:0];
            ersseq_pkg::RegHoldDrive:  hold_drive_ff  <= csr_wdata[DW-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- input register ----------------
   logic                   in_valid_ff;
   logic [CW-1:0]          in_chan_ff;
   logic [SPEED_WIDTH-1:0] in_m1_ff, in_m2_ff;
   logic                   in_raise_ff;
   logic                   advance;

   // The result register frees whenever it is empty or being taken; the input
   // stage moves forward in the same cycle, so a transaction can enter each cycle it frees.
   assign advance   = in_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_chan_ff  <= req_channel_value;
         in_m1_ff    <= req_motor1_rpm;
         in_m2_ff    <= req_motor2_rpm;
         in_raise_ff <= req_lift_raising;
      end
   end

   // ---------------- sequencer state ----------------
   logic                  prev_high_ff, prev_high_in;
   logic                  prev_low_ff,  prev_low_in;
   ersseq_pkg::phase_type phase_ff,     phase_in;
   logic                  seen_ff,      seen_in;
   logic [NW-1:0]         count_ff,     count_in;

   // Speed magnitudes: the most negative value maps to 2^(SPEED_WIDTH-1),
   // which still fits unsigned in SPEED_WIDTH bits.
   logic [SPEED_WIDTH-1:0] m1_mag, m2_mag;
   assign m1_mag = in_m1_ff[SPEED_WIDTH-1] ? SPEED_WIDTH'(~in_m1_ff + 1'b1) : in_m1_ff;
   assign m2_mag = in_m2_ff[SPEED_WIDTH-1] ? SPEED_WIDTH'(~in_m2_ff + 1'b1) : in_m2_ff;

   logic run_seen, both_stopped, is_high, is_low;
   assign run_seen = (CMP_W'(m1_mag) > CMP_W'(run_thresh_ff))
                  || (CMP_W'(m2_mag) > CMP_W'(run_thresh_ff));
   assign both_stopped = (CMP_W'(m1_mag) < CMP_W'(stop_thresh_ff))
                      && (CMP_W'(m2_mag) < CMP_W'(stop_thresh_ff));
   assign is_high = (in_chan_ff == chan_high_ff);
   assign is_low  = (in_chan_ff == chan_low_ff);

   logic [DW-1:0] drive_in;
   logic          ended_in;
   logic [NW-1:0] count_inc;

   always_comb begin
      phase_in = phase_ff;
      seen_in  = seen_ff;
      count_in = count_ff;
      drive_in = '0;
      ended_in = 1'b0;

      // Arrival edge on the high code commands retract, on the low code
      // extend; the high match wins when both codes are equal.
      if (is_high && !prev_high_ff) begin
         phase_in = ersseq_pkg::PH_RETRACTING;
         seen_in  = 1'b0;
         count_in = '0;
      end else if (is_low && !prev_low_ff) begin
         phase_in = ersseq_pkg::PH_EXTENDING;
         seen_in  = 1'b0;
         count_in = '0;
      end
      prev_high_in = is_high;
      prev_low_in  = is_low;

      count_inc = count_in + 1'b1;

      case (phase_in)
         ersseq_pkg::PH_EXTENDING, ersseq_pkg::PH_RETRACTING: begin
            drive_in = (phase_in == ersseq_pkg::PH_EXTENDING) ? ext_drive_ff : ret_drive_ff;
            if (run_seen) begin
               seen_in = 1'b1;
            end
            if (seen_in && both_stopped) begin
               // count the stalled tick; settle once the limit is reached
               if (count_inc >= stop_limit_ff) begin
                  drive_in = '0;
                  phase_in = (phase_in == ersseq_pkg::PH_EXTENDING)
                           ? ersseq_pkg::PH_EXTENDED : ersseq_pkg::PH_RETRACTED;
                  count_in = '0;
                  ended_in = 1'b1;
               end else begin
                  count_in = count_inc;
               end
            end else begin
               count_in = '0;
            end
         end
         ersseq_pkg::PH_EXTENDED: begin
            drive_in = '0;
         end
         ersseq_pkg::PH_RETRACTED: begin
            // hold the lift up while it is raising
            drive_in = in_raise_ff ? hold_drive_ff : '0;
         end
         default: begin
            drive_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_high_ff <= 1'b0;
         prev_low_ff  <= 1'b0;
         phase_ff     <= ersseq_pkg::PH_RETRACTED;
         seen_ff      <= 1'b0;
         count_ff     <= '0;
      end else if (advance) begin
         prev_high_ff <= prev_high_in;
         prev_low_ff  <= prev_low_in;
         phase_ff     <= phase_in;
         seen_ff      <= seen_in;
         count_ff     <= count_in;
      end
   end

   // ---------------- result register ----------------
   logic                        rsp_valid_ff;
   logic [DW-1:0]               rsp_drive_ff;
   logic [ersseq_pkg::StateWidth-1:0] rsp_state_ff;
   logic                        rsp_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_drive_ff <= drive_in;
         rsp_state_ff <= ersseq_pkg::phase_code(phase_in);
         rsp_end_ff   <= ended_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_value  = rsp_drive_ff;
   assign rsp_motion_state = rsp_state_ff;
   assign rsp_end_reached  = rsp_end_ff;

endmodule
